// ===== src/gcm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_pkg
// Shared constants, types and AES helper functions for the GCM block.
// ----------------------------------------------------------------------------
package gcm_pkg;

    localparam int KEY_BITS = 128;
    localparam int NK       = KEY_BITS / 32;
    localparam int NR       = NK + 6;
    localparam int NW       = 4 * (NR + 1);
    localparam int RK_IDX_W = $clog2(NR + 1);
    localparam int WIDX_W   = $clog2(NW);
    localparam int JW       = $clog2(NK);
    localparam int QDEPTH   = 2;
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    // Configuration register indexes
    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_DECR  = 3'd4;
    localparam logic [2:0] REG_NHIGH = 3'd5;
    localparam logic [2:0] REG_NTAIL = 3'd6;

    // Item passed from the front to the back
    typedef struct packed {
        logic         start;
        logic [127:0] data;
        logic [4:0]   nbytes;
    } q_item_t;

    // Queue status seen by the top level
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [QCNT_W-1:0] fill;
    } q_status_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // One AES round: sub bytes, shift rows, mix columns unless last, add key
    function automatic logic [127:0] aes_round(input logic [127:0] st,
                                               input logic [127:0] rk,
                                               input logic         last);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] o [16];
        logic [7:0] all;
        logic [127:0] res;
        for (int i = 0; i < 16; i++)
            b[i] = st[127 - 8 * i -: 8];
        for (int i = 0; i < 16; i++)
            t[i] = SBOX[b[(i + 4 * (i % 4)) % 16]];
        for (int c = 0; c < 4; c++)
        begin
            all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            o[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
            o[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
            o[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
            o[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
        end
        for (int i = 0; i < 16; i++)
            res[127 - 8 * i -: 8] = last ? t[i] : o[i];
        return res ^ rk;
    endfunction

endpackage

// ===== src/aes_gcm_authenticated_cipher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_gcm_authenticated_cipher
// AES-GCM payload cipher with running GHASH tag.
// ----------------------------------------------------------------------------
// Usage:
//   Program key, direction and nonce through wr_en/wr_index/wr_data while
//   idle. Send one 16-byte block per item on s_*; s_tuser marks the first
//   block of a message, which expands the key and computes H = E_K(0).
//   Each item returns one item on m_*: processed block and running tag.
// Sequence (NR = 10/12/14 rounds for 128/192/256-bit keys):
//   plain block: NR AES rounds, one round a cycle, then GHASH at eight
//   bits a cycle; the first block of a message first expands the key
//   and then encrypts the zero block for H.
//   The back end takes one item at a time; a two-item input queue keeps
//   s_tready high while it works, until the queue is full.
// Reset: queue empty, no output pending; counter set to one, tag cleared.
// Stall: a result waits in the output register while m_tready is low; the
//   next item is computed and then held until the register frees up.
// ----------------------------------------------------------------------------
module aes_gcm_authenticated_cipher
    import gcm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [2:0]   wr_index,
    input  logic [63:0]  wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // block_high, block_low, valid_bytes, zero pad
    input  logic         s_tuser,   // message_start
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata    // result_high, result_low, tag_high, tag_low
);

    logic [63:0] key_reg [4];
    logic        decr_reg;
    logic [63:0] nhigh_reg;
    logic [31:0] ntail_reg;
    logic        q_valid;
    logic        q_pop;
    q_item_t     q_item;
    q_status_t   q_status;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
                key_reg[k] <= '0;
            decr_reg  <= 1'b0;
            nhigh_reg <= '0;
            ntail_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_KEY0:  key_reg[0] <= wr_data;
                REG_KEY1:  key_reg[1] <= wr_data;
                REG_KEY2:  key_reg[2] <= wr_data;
                REG_KEY3:  key_reg[3] <= wr_data;
                REG_DECR:  decr_reg   <= wr_data[0];
                REG_NHIGH: nhigh_reg  <= wr_data;
                REG_NTAIL: ntail_reg  <= wr_data[31:0];
                default:   decr_reg   <= decr_reg;
            endcase
        end
    end

    gcm_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item),
        .q_status (q_status)
    );

    gcm_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .key        ({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
        .decrypting (decr_reg),
        .nonce_high (nhigh_reg),
        .nonce_tail (ntail_reg),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_item     (q_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // Queue never overfills
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.fill <= QCNT_W'(QDEPTH))
        else $error("queue fill above depth");

    // Push without pop grows the fill by one
    a_fill_push: assert property (@(posedge clk) disable iff (!rst_n)
        (q_status.push && !q_status.pop) |=> q_status.fill == $past(q_status.fill) + 1'b1)
        else $error("queue fill did not grow on push");

    // Pop only from a non-empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.pop |-> q_status.fill != '0)
        else $error("pop from empty queue");

endmodule

// ===== src/gcm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_front
// Accepts input items, normalizes the byte count, zeroes unused bytes and
// holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module gcm_front
    import gcm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // block_high, block_low, valid_bytes, pad
    input  logic         s_tuser,   // message_start
    output logic         q_valid,
    input  logic         q_pop,
    output q_item_t      q_item,
    output q_status_t    q_status
);

    q_item_t           mem_reg [QDEPTH];
    logic              wptr_reg, wptr_next;
    logic              rptr_reg, rptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic              push;
    logic              pop;
    logic [4:0]        nb;
    logic [127:0]      mask;
    q_item_t           item_in;

    // Classify: clamp byte count and mask unused bytes
    always_comb
    begin
        nb = s_tdata[132:128];
        if (nb == 5'd0 || nb > 5'd16)
            nb = 5'd16;
        for (int k = 0; k < 16; k++)
            mask[127 - 8 * k -: 8] = (5'(k) < nb) ? 8'hff : 8'h00;
        item_in.start  = s_tuser;
        item_in.data   = {s_tdata[63:0], s_tdata[127:64]} & mask;
        item_in.nbytes = nb;
    end

    assign s_tready = (fill_reg != QCNT_W'(QDEPTH));
    assign q_valid  = (fill_reg != '0);
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;
    assign q_item   = mem_reg[rptr_reg];
    assign q_status = '{push: push, pop: pop, fill: fill_reg};

    // Advance pointers and fill count
    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        fill_next = fill_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    // Store the item
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= item_in;
    end

endmodule

// ===== src/gcm_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_core
// Back end: key expansion, iterative AES, 8-bit-per-cycle GHASH and the
// output register.
// ----------------------------------------------------------------------------
module gcm_core
    import gcm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [255:0] key,
    input  logic         decrypting,
    input  logic [63:0]  nonce_high,
    input  logic [31:0]  nonce_tail,
    input  logic         q_valid,
    output logic         q_pop,
    input  q_item_t      q_item,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata    // result_high, result_low, tag_high, tag_low
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_KEXP = 3'd1;
    localparam logic [2:0] S_AES  = 3'd2;
    localparam logic [2:0] S_HASH = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]          state_reg;
    logic [127:0]        data_reg;
    logic [4:0]          nbytes_reg;
    logic [WIDX_W-1:0]   widx_reg;
    logic [JW-1:0]       j_reg;
    logic [7:0]          rcon_reg;
    logic [31:0]         win_reg [NK];
    logic [127:0]        rk_mem [NR + 1];
    logic [RK_IDX_W-1:0] round_reg;
    logic [127:0]        st_reg;
    logic                aes_h_reg;
    logic [31:0]         ctr_reg;
    logic [127:0]        tag_reg;
    logic [127:0]        h_reg;
    logic [127:0]        res_reg;
    logic [127:0]        a_reg;
    logic [127:0]        z_reg;
    logic [127:0]        v_reg;
    logic [3:0]          gcnt_reg;
    logic                out_valid_reg;
    logic [255:0]        out_data_reg;

    logic [31:0]  prev;
    logic [31:0]  tword;
    logic [31:0]  kword;
    logic [127:0] round_out;
    logic [127:0] ctr_block;
    logic [127:0] mask;
    logic [127:0] ct;
    logic [127:0] z_step;
    logic [127:0] v_step;
    logic         out_free;

    // Key schedule word generation
    always_comb
    begin
        prev = win_reg[NK-1];
        if (j_reg == '0)
            tword = sub_word({prev[23:0], prev[31:24]}) ^ {rcon_reg, 24'h0};
        else if (NK > 6 && int'(j_reg) == 4)
            tword = sub_word(prev);
        else
            tword = prev;
        if (widx_reg < WIDX_W'(NK))
            kword = key[255 - 32 * widx_reg -: 32];
        else
            kword = win_reg[0] ^ tword;
    end

    // AES round, counter block, payload mask
    always_comb
    begin
        round_out = aes_round(st_reg, rk_mem[round_reg], round_reg == RK_IDX_W'(NR));
        ctr_block = {nonce_high, nonce_tail, ctr_reg + 32'd1};
        for (int k = 0; k < 16; k++)
            mask[127 - 8 * k -: 8] = (5'(k) < nbytes_reg) ? 8'hff : 8'h00;
        ct = (data_reg ^ round_out) & mask;
    end

    // Eight GHASH bit steps
    always_comb
    begin
        z_step = z_reg;
        v_step = v_reg;
        for (int b = 0; b < 8; b++)
        begin
            if (a_reg[127 - b])
                z_step = z_step ^ v_step;
            v_step = {1'b0, v_step[127:1]} ^ (v_step[0] ? {8'he1, 120'h0} : 128'h0);
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            ctr_reg       <= 32'd1;
            tag_reg       <= '0;
        end
        else
        begin
            // Load the output register or release it once taken
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_item.start)
                        begin
                            ctr_reg   <= 32'd1;
                            tag_reg   <= '0;
                            state_reg <= S_KEXP;
                        end
                        else
                        begin
                            ctr_reg   <= ctr_reg + 32'd1;
                            state_reg <= S_AES;
                        end
                    end
                end
                S_KEXP:
                begin
                    if (widx_reg == WIDX_W'(NW - 1))
                        state_reg <= S_AES;
                end
                S_AES:
                begin
                    if (round_reg == RK_IDX_W'(NR))
                    begin
                        if (aes_h_reg)
                            ctr_reg <= ctr_reg + 32'd1;
                        else
                            state_reg <= S_HASH;
                    end
                end
                S_HASH:
                begin
                    if (gcnt_reg == 4'd15)
                    begin
                        tag_reg   <= z_step;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    data_reg   <= q_item.data;
                    nbytes_reg <= q_item.nbytes;
                    widx_reg   <= '0;
                    j_reg      <= '0;
                    rcon_reg   <= 8'h01;
                    aes_h_reg  <= 1'b0;
                    round_reg  <= RK_IDX_W'(1);
                    st_reg     <= ctr_block ^ rk_mem[0];
                end
            end
            S_KEXP:
            begin
                rk_mem[RK_IDX_W'(widx_reg >> 2)][127 - 32 * widx_reg[1:0] -: 32] <= kword;
                for (int k = 0; k < NK - 1; k++)
                    win_reg[k] <= win_reg[k + 1];
                win_reg[NK-1] <= kword;
                widx_reg      <= widx_reg + WIDX_W'(1);
                j_reg         <= (j_reg == JW'(NK - 1)) ? '0 : j_reg + JW'(1);
                if (j_reg == '0 && widx_reg >= WIDX_W'(NK))
                    rcon_reg <= xtime(rcon_reg);
                if (widx_reg == WIDX_W'(NW - 1))
                begin
                    aes_h_reg <= 1'b1;
                    round_reg <= RK_IDX_W'(1);
                    st_reg    <= rk_mem[0];
                end
            end
            S_AES:
            begin
                if (round_reg == RK_IDX_W'(NR))
                begin
                    round_reg <= RK_IDX_W'(1);
                    if (aes_h_reg)
                    begin
                        h_reg     <= round_out;
                        aes_h_reg <= 1'b0;
                        st_reg    <= ctr_block ^ rk_mem[0];
                    end
                    else
                    begin
                        res_reg  <= ct;
                        a_reg    <= tag_reg ^ (decrypting ? data_reg : ct);
                        z_reg    <= '0;
                        v_reg    <= h_reg;
                        gcnt_reg <= '0;
                    end
                end
                else
                begin
                    st_reg    <= round_out;
                    round_reg <= round_reg + RK_IDX_W'(1);
                end
            end
            S_HASH:
            begin
                z_reg    <= z_step;
                v_reg    <= v_step;
                a_reg    <= {a_reg[119:0], 8'h00};
                gcnt_reg <= gcnt_reg + 4'd1;
            end
            S_DONE:
            begin
                if (out_free)
                    out_data_reg <= {tag_reg[63:0], tag_reg[127:64],
                                     res_reg[63:0], res_reg[127:64]};
            end
            default:
            begin
                st_reg <= st_reg;
            end
        endcase
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the AES-GCM payload cipher. A scoreboard predicts
// each processed block and the running GHASH tag from its own AES and GHASH
// code. Stimulus runs directed blocks, then random messages under several
// key, nonce and direction settings, with random stalls or a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top
    import gcm_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 150;

    // Predicts cipher output and tag; holds expected results in order
    class gcm_scoreboard;
        logic [63:0]  key_reg [4];
        logic         decrypt_reg;
        logic [63:0]  nonce_hi_reg;
        logic [31:0]  nonce_lo_reg;
        logic [31:0]  ctr;
        logic [127:0] tag;
        logic [127:0] hkey;
        logic [127:0] rkey [15];
        logic [255:0] expected_q [$];
        int           errors;

        function new();
            for (int i = 0; i < 4; i++)
                key_reg[i] = '0;
            decrypt_reg  = 1'b0;
            nonce_hi_reg = '0;
            nonce_lo_reg = '0;
            ctr          = 32'd1;
            tag          = '0;
            hkey         = '0;
            for (int i = 0; i < 15; i++)
                rkey[i] = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] val);
            case (idx)
                REG_KEY0:  key_reg[0]   = val;
                REG_KEY1:  key_reg[1]   = val;
                REG_KEY2:  key_reg[2]   = val;
                REG_KEY3:  key_reg[3]   = val;
                REG_DECR:  decrypt_reg  = val[0];
                REG_NHIGH: nonce_hi_reg = val;
                REG_NTAIL: nonce_lo_reg = val[31:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] dbl(logic [7:0] b);
            return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
        endfunction

        function logic [31:0] sbox_word(logic [31:0] w);
            return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
        endfunction

        function void build_schedule();
            logic [31:0] w [60];
            logic [31:0] t;
            logic [7:0]  rc;
            int          nk;
            int          total;
            nk    = KEY_BITS / 32;
            total = 4 * (nk + 7);
            rc    = 8'h01;
            for (int i = 0; i < nk; i++)
                w[i] = (i % 2) ? key_reg[i / 2][31:0] : key_reg[i / 2][63:32];
            for (int i = nk; i < total; i++)
            begin
                t = w[i - 1];
                if (i % nk == 0)
                begin
                    t  = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                    rc = dbl(rc);
                end
                else if (nk > 6 && i % nk == 4)
                    t = sbox_word(t);
                w[i] = w[i - nk] ^ t;
            end
            for (int r = 0; r < total / 4; r++)
                rkey[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
        endfunction

        function logic [127:0] cipher(logic [127:0] blk);
            logic [7:0] s [16];
            logic [7:0] t [16];
            logic [7:0] all;
            logic [127:0] st;
            int nr;
            nr = KEY_BITS / 32 + 6;
            st = blk ^ rkey[0];
            for (int r = 1; r <= nr; r++)
            begin
                for (int i = 0; i < 16; i++)
                    s[i] = st[127 - 8*i -: 8];
                for (int i = 0; i < 16; i++)
                    t[i] = SBOX[s[(i + 4 * (i % 4)) % 16]];
                for (int c = 0; c < 4; c++)
                begin
                    all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
                    s[4*c]   = t[4*c]   ^ all ^ dbl(t[4*c]   ^ t[4*c+1]);
                    s[4*c+1] = t[4*c+1] ^ all ^ dbl(t[4*c+1] ^ t[4*c+2]);
                    s[4*c+2] = t[4*c+2] ^ all ^ dbl(t[4*c+2] ^ t[4*c+3]);
                    s[4*c+3] = t[4*c+3] ^ all ^ dbl(t[4*c+3] ^ t[4*c]);
                end
                for (int i = 0; i < 16; i++)
                    st[127 - 8*i -: 8] = (r == nr) ? t[i] : s[i];
                st = st ^ rkey[r];
            end
            return st;
        endfunction

        // Fold one block into the tag: multiply by H in GF(2^128)
        function void fold(logic [127:0] x);
            logic [127:0] a, z, v;
            logic         carry;
            a = tag ^ x;
            z = '0;
            v = hkey;
            for (int i = 0; i < 128; i++)
            begin
                carry = v[0];
                if (a[127 - i])
                    z ^= v;
                v = v >> 1;
                if (carry)
                    v[127:120] ^= 8'he1;
            end
            tag = z;
        endfunction

        function void note_block(logic start, logic [63:0] hi, logic [63:0] lo,
                                 logic [4:0] nb);
            logic [127:0] mask, din, ks, res;
            int n;
            n = int'(nb);
            if (n == 0 || n > 16)
                n = 16;
            if (start)
            begin
                build_schedule();
                hkey = cipher('0);
                ctr  = 32'd1;
                tag  = '0;
            end
            mask = (n == 16) ? {128{1'b1}} : ~({128{1'b1}} >> (8 * n));
            din  = {hi, lo} & mask;
            ctr  = ctr + 32'd1;
            ks   = cipher({nonce_hi_reg, nonce_lo_reg, ctr});
            res  = (din ^ ks) & mask;
            fold(decrypt_reg ? din : res);
            expected_q.push_back({tag[63:0], tag[127:64], res[63:0], res[127:64]});
        endfunction

        function void check_result(logic [255:0] got);
            logic [255:0] exp_val;
            string        fname [4];
            fname = '{"result_high", "result_low", "tag_high", "tag_low"};
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_val = expected_q.pop_front();
            for (int f = 0; f < 4; f++)
                if (got[64*f +: 64] !== exp_val[64*f +: 64])
                begin
                    $display("%0t: %s expected %h actual %h", $time, fname[f],
                             exp_val[64*f +: 64], got[64*f +: 64]);
                    errors++;
                end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         wr_en;
    logic [2:0]   wr_index;
    logic [63:0]  wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;   // block_high, block_low, valid_bytes, zero pad
    logic         s_tuser;   // message_start
    logic         m_tvalid;
    logic         m_tready;
    logic [255:0] m_tdata;   // result_high, result_low, tag_high, tag_low

    gcm_scoreboard sb;
    int            tx_idle_pct;
    int            rx_idle_pct;
    int            hold_cycles;
    int            quiet_cycles;

    aes_gcm_authenticated_cipher u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Check results and watch for a stuck block
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        wr_en    <= 1'b0;
    endtask

    task automatic program_all(input logic [63:0] k0, input logic [63:0] k1,
                               input logic [63:0] k2, input logic [63:0] k3,
                               input logic dec, input logic [63:0] nh,
                               input logic [31:0] nt);
        write_reg(REG_KEY0, k0);
        write_reg(REG_KEY1, k1);
        write_reg(REG_KEY2, k2);
        write_reg(REG_KEY3, k3);
        write_reg(REG_DECR, {63'h0, dec});
        write_reg(REG_NHIGH, nh);
        write_reg(REG_NTAIL, {32'h0, nt});
    endtask

    // Offer one item, optionally after an idle gap, and wait for acceptance
    task automatic send_block(input logic start, input logic [63:0] hi,
                              input logic [63:0] lo, input logic [4:0] nb);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= start;
        s_tdata  <= {3'b0, nb, lo, hi};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_block(start, hi, lo, nb);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random messages; a few continue without a start
    task automatic random_traffic(input int count);
        int          sent;
        int          len;
        logic        first;
        logic [4:0]  nb;
        sent  = 0;
        first = 1'b1;
        while (sent < count)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
            begin
                nb = 5'd16;
                if (i == len - 1 && $urandom_range(1))
                    nb = 5'($urandom_range(1, 15));
                else if ($urandom_range(39) == 0)
                    nb = 5'($urandom_range(1, 15));
                if ($urandom_range(29) == 0)
                    nb = $urandom_range(1) ? 5'd0 : 5'($urandom_range(17, 31));
                send_block((i == 0) && (first || $urandom_range(9) != 0),
                           {$urandom, $urandom}, {$urandom, $urandom}, nb);
                first = 1'b0;
                sent++;
            end
        end
    endtask

    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        wr_en       = 1'b0;
        wr_index    = '0;
        wr_data     = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero key and nonce, extremes of data and byte counts
        program_all('0, '0, '0, '0, 1'b0, '0, '0);
        send_block(1'b1, '0, '0, 5'd16);
        send_block(1'b0, '1, '1, 5'd16);
        send_block(1'b0, '1, '1, 5'd1);
        send_block(1'b1, '1, '1, 5'd8);
        send_block(1'b0, '1, '1, 5'd9);
        send_block(1'b0, '1, '1, 5'd15);
        send_block(1'b0, '1, '1, 5'd0);
        send_block(1'b0, '1, '1, 5'd31);
        send_block(1'b0, '1, '1, 5'd17);
        send_block(1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210, 5'd16);
        send_block(1'b1, '1, '0, 5'd16);
        send_block(1'b1, '0, '1, 5'd12);
        drain();

        // All-ones key and nonce, decrypt; sender rarely idles
        program_all('1, '1, '1, '1, 1'b1, '1, '1);
        tx_idle_pct = 13;
        rx_idle_pct = 65;
        send_block(1'b1, '0, '0, 5'd16);
        send_block(1'b0, '1, '1, 5'd7);
        random_traffic(300);
        drain();

        // Random key and nonce, encrypt; receiver rarely idles
        program_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, 1'b0, {$urandom, $urandom}, $urandom);
        tx_idle_pct = 65;
        rx_idle_pct = 13;
        random_traffic(300);
        drain();

        // Random key, decrypt; no idling, long receiver hold-off first
        program_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, 1'b1, {$urandom, $urandom}, $urandom);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_cycles = 400;
        random_traffic(320);
        drain();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
src/gcm_pkg.sv
src/gcm_front.sv
src/gcm_core.sv
src/aes_gcm_authenticated_cipher.sv
bench/tb_top.sv
